@@ hdl/modular_arith_unit_64_core_defines.svh @@
// Assertion macros for the modular arithmetic unit.
// Used by modular_arith_unit_64_core.sv; needs clk and rst_n in scope.
`ifndef MODULAR_ARITH_UNIT_64_CORE_DEFINES_SVH
`define MODULAR_ARITH_UNIT_64_CORE_DEFINES_SVH

// Implication checked every cycle, once the block is out of reset.
`define MAU_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define MAU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/mau_pkg.sv @@
// Shared constants for the modular arithmetic unit.
// No dependencies; used by modular_arith_unit_64_core.sv.
`default_nettype none

package mau_pkg;
    localparam int unsigned WORD_W   = 64;
    localparam int unsigned HALF_W   = 32;
    localparam int unsigned CMD_W    = 3;
    localparam int unsigned IN_W     = 136;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned REM_STAGES = 64;

    localparam logic [CMD_W-1:0] CMD_MONT_MUL  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ADD       = 3'd1;
    localparam logic [CMD_W-1:0] CMD_SUB       = 3'd2;
    localparam logic [CMD_W-1:0] CMD_TO_MONT   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_FROM_MONT = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_MODULUS     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NEG_INVERSE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_R_SQUARED   = 2'd2;
endpackage

`default_nettype wire

@@ hdl/modular_arith_unit_64_core.sv @@
// Top level of the modular arithmetic unit: a 64-bit Montgomery multiplier and
// modular add/subtract in one 65-stage pipeline. Depends on mau_pkg.sv and on
// modular_arith_unit_64_core_defines.svh for assertion macros.
//
// Usage: a request enters on the s_axis channel (tdata holds command, operand_a,
// operand_b) and one result leaves on m_axis (tdata holds value) for every request.
// The modulus, -q^-1 mod 2^64 and R^2 mod q are loaded through cfg_wen/cfg_index/
// cfg_wdata while no request is in flight; index 3 is ignored.
// m_axis_tvalid rises once an accepted request has passed through every remainder
// stage and the output register.
// The depth is set by the full reduction of the add and subtract operands, a
// restoring remainder that retires one dividend bit per stage over 64 stages.
// The Montgomery path (three rounds of split 32-bit multiplies, an addition of the
// 128-bit sum and one conditional subtraction) takes the first eight stages and its
// result is then carried alongside. One request per cycle unless the output stalls.
// All stages advance together; when the receiver holds m_axis_tready low with a
// result waiting, the whole pipeline holds and s_axis_tready drops, so nothing is
// lost or repeated. Bubbles in the pipe still advance while the output is empty.
// Reset clears all valid bits and loads modulus 1, neg_inverse all ones and
// r_squared 0.
`default_nettype none
`include "modular_arith_unit_64_core_defines.svh"

module modular_arith_unit_64_core (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    // [2:0] command, [66:3] operand_a, [130:67] operand_b, [135:131] zero
    input  wire logic [mau_pkg::IN_W-1:0]      s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // [63:0] value
    output logic [mau_pkg::WORD_W-1:0]         m_axis_tdata,
    input  wire logic                          cfg_wen,
    input  wire logic [mau_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [mau_pkg::WORD_W-1:0]    cfg_wdata
);
    localparam int unsigned W = mau_pkg::WORD_W;
    localparam int unsigned H = mau_pkg::HALF_W;
    localparam int unsigned N = mau_pkg::REM_STAGES;

    // Configuration registers.
    logic [W-1:0] modulus_reg, neg_inv_reg, r_sq_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg <= W'(1);
            neg_inv_reg <= '1;
            r_sq_reg    <= '0;
        end
        else if (cfg_wen)
        begin
            unique case (cfg_index)
                mau_pkg::REG_MODULUS:     modulus_reg <= cfg_wdata;
                mau_pkg::REG_NEG_INVERSE: neg_inv_reg <= cfg_wdata;
                mau_pkg::REG_R_SQUARED:   r_sq_reg    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Request fields.
    logic [mau_pkg::CMD_W-1:0] in_cmd;
    logic [W-1:0] in_a, in_b;
    assign in_cmd = s_axis_tdata[2:0];
    assign in_a   = s_axis_tdata[66:3];
    assign in_b   = s_axis_tdata[130:67];

    // Global advance: the pipe moves unless a result waits on a stalled receiver.
    logic en;
    logic out_vld_reg;
    logic [W-1:0] out_data_reg;
    assign en            = !out_vld_reg || m_axis_tready;
    assign s_axis_tready = en;

    // Per-stage control and remainder state.
    logic                      vld_reg  [0:N-1];
    logic [mau_pkg::CMD_W-1:0] cmd_reg  [0:N-1];
    logic [W-1:0]              src_a_reg [0:N-1];
    logic [W-1:0]              src_b_reg [0:N-1];
    logic [W-1:0]              rem_a_reg [0:N-1];
    logic [W-1:0]              rem_b_reg [0:N-1];
    logic [W-1:0]              mont_d_reg [8:N-1];

    for (genvar k = 0; k < N; k++)
    begin : g_rem
        logic                      vld_in;
        logic [mau_pkg::CMD_W-1:0] cmd_in;
        logic [W-1:0]              sa_in, sb_in, ra_in, rb_in;
        logic [W:0]                ta, tb;
        logic [W-1:0]              ra_next, rb_next;

        if (k == 0)
        begin : g_first
            assign vld_in = s_axis_tvalid;
            assign cmd_in = in_cmd;
            assign sa_in  = in_a;
            assign sb_in  = in_b;
            assign ra_in  = '0;
            assign rb_in  = '0;
        end
        else
        begin : g_next
            assign vld_in = vld_reg[k-1];
            assign cmd_in = cmd_reg[k-1];
            assign sa_in  = src_a_reg[k-1];
            assign sb_in  = src_b_reg[k-1];
            assign ra_in  = rem_a_reg[k-1];
            assign rb_in  = rem_b_reg[k-1];
        end

        // One restoring step: shift in the next dividend bit, subtract q if it fits.
        // With q zero nothing is subtracted and the operand passes through whole.
        always_comb
        begin
            ta = {ra_in, sa_in[N-1-k]};
            tb = {rb_in, sb_in[N-1-k]};
            ra_next = ta[W-1:0];
            rb_next = tb[W-1:0];
            if (modulus_reg != '0 && ta >= {1'b0, modulus_reg})
                ra_next = W'(ta - {1'b0, modulus_reg});
            if (modulus_reg != '0 && tb >= {1'b0, modulus_reg})
                rb_next = W'(tb - {1'b0, modulus_reg});
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k] <= 1'b0;
            else if (en)
                vld_reg[k] <= vld_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                cmd_reg[k]   <= cmd_in;
                src_a_reg[k] <= sa_in;
                src_b_reg[k] <= sb_in;
                rem_a_reg[k] <= ra_next;
                rem_b_reg[k] <= rb_next;
            end
        end
    end

    // Montgomery path, stages 0 to 7.
    logic [W-1:0] mul_y;
    always_comb
    begin
        case (in_cmd)
            mau_pkg::CMD_TO_MONT:   mul_y = r_sq_reg;
            mau_pkg::CMD_FROM_MONT: mul_y = W'(1);
            default:                mul_y = in_b;
        endcase
    end

    logic [W-1:0] p00_reg, p01_reg, p10_reg, p11_reg;            // stage 0
    logic [W-1:0] lo1_reg, hi1_reg;                              // stage 1
    logic [W-1:0] lo2_reg, hi2_reg, q00_reg;                     // stage 2
    logic [H-1:0] q01_reg, q10_reg;
    logic [W-1:0] lo3_reg, hi3_reg, m3_reg;                      // stage 3
    logic [W-1:0] lo4_reg, hi4_reg, r00_reg, r01_reg, r10_reg, r11_reg; // stage 4
    logic [W-1:0] lo5_reg, hi5_reg, mql5_reg, mqh5_reg;          // stage 5
    logic [W-1:0] t6_reg;                                        // stage 6
    logic [W-1:0] mont7_reg;                                     // stage 7

    logic [H+1:0] mid1, mid5;
    logic [W:0]   low_sum6;
    logic [W-1:0] m_next;

    assign mid1 = (H+2)'(p00_reg[W-1:H]) + (H+2)'(p01_reg[H-1:0]) + (H+2)'(p10_reg[H-1:0]);
    assign m_next = q00_reg + {q01_reg + q10_reg, {H{1'b0}}};
    assign mid5 = (H+2)'(r00_reg[W-1:H]) + (H+2)'(r01_reg[H-1:0]) + (H+2)'(r10_reg[H-1:0]);
    assign low_sum6 = {1'b0, lo5_reg} + {1'b0, mql5_reg};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p00_reg <= W'(in_a[H-1:0]) * W'(mul_y[H-1:0]);
            p01_reg <= W'(in_a[H-1:0]) * W'(mul_y[W-1:H]);
            p10_reg <= W'(in_a[W-1:H]) * W'(mul_y[H-1:0]);
            p11_reg <= W'(in_a[W-1:H]) * W'(mul_y[W-1:H]);

            lo1_reg <= {mid1[H-1:0], p00_reg[H-1:0]};
            hi1_reg <= p11_reg + W'(p01_reg[W-1:H]) + W'(p10_reg[W-1:H]) + W'(mid1[H+1:H]);

            // m = lo * neg_inverse mod 2^64: only the low cross products matter.
            lo2_reg <= lo1_reg;
            hi2_reg <= hi1_reg;
            q00_reg <= W'(lo1_reg[H-1:0]) * W'(neg_inv_reg[H-1:0]);
            q01_reg <= H'(W'(lo1_reg[H-1:0]) * W'(neg_inv_reg[W-1:H]));
            q10_reg <= H'(W'(lo1_reg[W-1:H]) * W'(neg_inv_reg[H-1:0]));

            lo3_reg <= lo2_reg;
            hi3_reg <= hi2_reg;
            m3_reg  <= m_next;

            lo4_reg <= lo3_reg;
            hi4_reg <= hi3_reg;
            r00_reg <= W'(m3_reg[H-1:0]) * W'(modulus_reg[H-1:0]);
            r01_reg <= W'(m3_reg[H-1:0]) * W'(modulus_reg[W-1:H]);
            r10_reg <= W'(m3_reg[W-1:H]) * W'(modulus_reg[H-1:0]);
            r11_reg <= W'(m3_reg[W-1:H]) * W'(modulus_reg[W-1:H]);

            lo5_reg  <= lo4_reg;
            hi5_reg  <= hi4_reg;
            mql5_reg <= {mid5[H-1:0], r00_reg[H-1:0]};
            mqh5_reg <= r11_reg + W'(r01_reg[W-1:H]) + W'(r10_reg[W-1:H])
                        + W'(mid5[H+1:H]);

            // High half of the wrapping 128-bit sum a*b + m*q.
            t6_reg <= hi5_reg + mqh5_reg + W'(low_sum6[W]);

            mont7_reg <= (t6_reg >= modulus_reg) ? t6_reg - modulus_reg : t6_reg;
        end
    end

    for (genvar k = 8; k < N; k++)
    begin : g_mdly
        always_ff @(posedge clk)
        begin
            if (en)
                mont_d_reg[k] <= (k == 8) ? mont7_reg : mont_d_reg[(k > 8) ? k-1 : k];
        end
    end

    // Final stage: pick the result by command.
    logic [W-1:0] x_red, y_red, res_next;
    logic [W:0]   sum;
    assign x_red = rem_a_reg[N-1];
    assign y_red = rem_b_reg[N-1];
    assign sum   = {1'b0, x_red} + {1'b0, y_red};

    always_comb
    begin
        case (cmd_reg[N-1]) inside
            mau_pkg::CMD_MONT_MUL, mau_pkg::CMD_TO_MONT, mau_pkg::CMD_FROM_MONT:
                res_next = mont_d_reg[N-1];
            mau_pkg::CMD_ADD:
                res_next = (sum[W] || sum[W-1:0] >= modulus_reg)
                           ? sum[W-1:0] - modulus_reg : sum[W-1:0];
            mau_pkg::CMD_SUB:
                res_next = (x_red >= y_red) ? x_red - y_red
                                            : modulus_reg - (y_red - x_red);
            default:
                res_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (en)
            out_vld_reg <= vld_reg[N-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            out_data_reg <= res_next;
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = out_data_reg;

    // A result held by the receiver must still be there next cycle.
    `MAU_ASSERT_NEXT(a_hold_result, out_vld_reg && !m_axis_tready, out_vld_reg, "result dropped")
    // Input is taken exactly when the pipe advances.
    `MAU_ASSERT_IMPL(a_ready_en, 1'b1, s_axis_tready == en, "ready differs from advance")
    // The last stage always lands in the output register when the pipe moves.
    `MAU_ASSERT_NEXT(a_last_to_out, en && vld_reg[N-1], out_vld_reg, "last stage lost")

endmodule

`default_nettype wire
